// ----- rtl/rqet_pkg.sv -----
package rqet_pkg;

	localparam int MAX_READ_LEN = 1024;
	localparam int IDX_W = $clog2(MAX_READ_LEN);
	localparam int CNT_W = $clog2(MAX_READ_LEN + 1);
	localparam int LEN_W = 11;
	localparam int QW = 7;
	localparam int BYTE_W = 8;
	localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam int CFG_IDX_W = 2;
	localparam int QUAL_MAX = 93;

	typedef enum logic [1:0] {
		ST_KEEP     = 2'd0,
		ST_DISCARD  = 2'd1,
		ST_INVALID  = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_START_Q = 2'd0,
		CFG_MIN_END_Q   = 2'd1,
		CFG_MIN_LEN     = 2'd2,
		CFG_Q_OFFSET    = 2'd3
	} cfg_idx_t;

	// per-read summary handed to the verdict stage
	typedef struct packed {
		logic             valid;
		logic             overflow;
		logic [CNT_W-1:0] count;
		logic             start_found;
		logic [IDX_W-1:0] start_idx;
		logic             end_found;
		logic [IDX_W-1:0] end_idx;
		logic             tail_bad;
	} read_sum_t;

	// a zero minimum acts as one
	function automatic logic [CMP_W-1:0] eff_min_len(input logic [LEN_W-1:0] mrl);
		logic [CMP_W-1:0] r;
		r = (mrl == '0) ? CMP_W'(1) : CMP_W'(mrl);
		return r;
	endfunction

endpackage

// ----- rtl/rqet_qual_if.sv -----
interface rqet_qual_if;
	import rqet_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] quality_byte;
	logic              last_base;

	modport source (output valid, quality_byte, last_base, input ready);
	modport sink (input valid, quality_byte, last_base, output ready);
endinterface

// ----- rtl/rqet_res_if.sv -----
interface rqet_res_if;
	import rqet_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic [IDX_W-1:0] start_pos;
	logic [IDX_W-1:0] end_pos;
	logic [CNT_W-1:0] kept_length;

	modport source (output valid, status, start_pos, end_pos, kept_length, input ready);
	modport sink (input valid, status, start_pos, end_pos, kept_length, output ready);
endinterface

// ----- rtl/read_quality_end_trimmer.sv -----
// Quality end trimmer: takes one ASCII quality byte per item, up to one item
// per clock with no gaps unless a held result stalls the input, and gives one
// result item per read on its last byte (status 0 keep, 1 discard, 2 invalid
// quality, 3 read longer than 1024 bytes; positions and kept length are zero
// unless kept). The result of a read passes through the input register, where
// the byte updates the running per-read state, and then the result register.
// The state resets to zero and clears after every last byte.
// A held result stalls the next last byte in the input register, and the bytes
// behind it wait with it; the bytes before it keep flowing.
// Configuration is written on cfg_we with cfg_index 0 min start quality,
// 1 min end quality, 2 min read length (0 acts as 1), 3 quality offset; write
// it only while no read is in flight.
module read_quality_end_trimmer
	import rqet_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	rqet_qual_if.sink            qual,
	rqet_res_if.source           res
);

	logic [QW-1:0]    min_start_q_q, min_end_q_q, q_offset_q;
	logic [LEN_W-1:0] min_len_q;
	read_sum_t        sum;
	logic             res_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_start_q_q <= QW'(0);
			min_end_q_q <= QW'(3);
			min_len_q <= LEN_W'(60);
			q_offset_q <= QW'(33);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MIN_START_Q: min_start_q_q <= cfg_data[QW-1:0];
				CFG_MIN_END_Q:   min_end_q_q <= cfg_data[QW-1:0];
				CFG_MIN_LEN:     min_len_q <= cfg_data;
				CFG_Q_OFFSET:    q_offset_q <= cfg_data[QW-1:0];
				default:         ;
			endcase
		end
	end

	rqet_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.qual        (qual),
		.min_start_q (min_start_q_q),
		.min_end_q   (min_end_q_q),
		.min_len     (min_len_q),
		.q_offset    (q_offset_q),
		.res_free    (res_free),
		.sum         (sum)
	);

	rqet_verdict u_verdict (
		.clk      (clk),
		.arst_n   (arst_n),
		.sum      (sum),
		.min_len  (min_len_q),
		.res_free (res_free),
		.res      (res)
	);

endmodule

// ----- rtl/rqet_scan.sv -----
module rqet_scan
	import rqet_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	rqet_qual_if.sink        qual,
	input  logic [QW-1:0]    min_start_q,
	input  logic [QW-1:0]    min_end_q,
	input  logic [LEN_W-1:0] min_len,
	input  logic [QW-1:0]    q_offset,
	input  logic             res_free,
	output read_sum_t        sum
);

	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              adv_s1;

	logic [CNT_W-1:0]  base_q;
	logic              sf_q, ef_q, tb_q, ovf_q;
	logic [IDX_W-1:0]  si_q, ei_q;

	logic [CNT_W-1:0]  nx_base;
	logic              nx_sf, nx_ef, nx_tb, nx_ovf;
	logic [IDX_W-1:0]  nx_si, nx_ei;

	logic signed [BYTE_W:0] q;
	logic              bad, q_ge_start, q_ge_end, in_tail;
	logic [CMP_W-1:0]  minlen;
	logic [IDX_W-1:0]  idx;

	// a last byte waits in the input register until the result register frees
	assign adv_s1 = v_s1 && (!last_s1 || res_free);
	assign qual.ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (qual.valid && qual.ready) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (qual.valid && qual.ready) begin
			byte_s1 <= qual.quality_byte;
			last_s1 <= qual.last_base;
		end
	end

	assign q = $signed({1'b0, byte_s1}) - $signed({{(BYTE_W + 1 - QW){1'b0}}, q_offset});
	assign bad = (q < 0) || (q > $signed((BYTE_W + 1)'(QUAL_MAX)));
	assign q_ge_start = q >= $signed({{(BYTE_W + 1 - QW){1'b0}}, min_start_q});
	assign q_ge_end = q >= $signed({{(BYTE_W + 1 - QW){1'b0}}, min_end_q});
	assign minlen = eff_min_len(min_len);
	assign idx = base_q[IDX_W-1:0];
	assign in_tail = (CMP_W'(base_q) + CMP_W'(1)) >= minlen;

	always_comb begin
		nx_base = base_q;
		nx_sf = sf_q;
		nx_si = si_q;
		nx_ef = ef_q;
		nx_ei = ei_q;
		nx_tb = tb_q;
		nx_ovf = ovf_q;
		if (!ovf_q) begin
			if (base_q >= CNT_W'(MAX_READ_LEN)) begin
				nx_ovf = 1'b1;
			end else begin
				if (!sf_q && q_ge_start) begin
					nx_sf = 1'b1;
					nx_si = idx;
				end
				if (in_tail) begin
					if (q_ge_end) begin
						nx_ef = 1'b1;
						nx_ei = idx;
						nx_tb = bad;
					end else if (bad) begin
						nx_tb = 1'b1;
					end
				end
				nx_base = base_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			sf_q <= 1'b0;
			si_q <= '0;
			ef_q <= 1'b0;
			ei_q <= '0;
			tb_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (adv_s1) begin
			if (last_s1) begin
				base_q <= '0;
				sf_q <= 1'b0;
				si_q <= '0;
				ef_q <= 1'b0;
				ei_q <= '0;
				tb_q <= 1'b0;
				ovf_q <= 1'b0;
			end else begin
				base_q <= nx_base;
				sf_q <= nx_sf;
				si_q <= nx_si;
				ef_q <= nx_ef;
				ei_q <= nx_ei;
				tb_q <= nx_tb;
				ovf_q <= nx_ovf;
			end
		end
	end

	always_comb begin
		sum.valid = adv_s1 && last_s1;
		sum.overflow = nx_ovf;
		sum.count = nx_base;
		sum.start_found = nx_sf;
		sum.start_idx = nx_si;
		sum.end_found = nx_ef;
		sum.end_idx = nx_ei;
		sum.tail_bad = nx_tb;
	end

`ifndef ASSERT_OFF
	a_base_bound: assert property (@(posedge clk) disable iff (!arst_n)
		base_q <= CNT_W'(MAX_READ_LEN))
		else $error("base index past read limit");
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> base_q == '0 && !ovf_q && !sf_q && !ef_q)
		else $error("per-read state not cleared");
	a_end_seen: assert property (@(posedge clk) disable iff (!arst_n)
		ef_q |-> CNT_W'(ei_q) < base_q)
		else $error("end index beyond bases seen");
	a_start_seen: assert property (@(posedge clk) disable iff (!arst_n)
		sf_q |-> CNT_W'(si_q) < base_q)
		else $error("start index beyond bases seen");
`endif

endmodule

// ----- rtl/rqet_verdict.sv -----
module rqet_verdict
	import rqet_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  read_sum_t        sum,
	input  logic [LEN_W-1:0] min_len,
	output logic             res_free,
	rqet_res_if.source       res
);

	logic [CMP_W-1:0] minlen, n, lim, klen;
	logic             too_short, start_bad, trim_short;
	status_t          st;
	logic             v_q;
	status_t          st_q;
	logic [IDX_W-1:0] sp_q, ep_q;
	logic [CNT_W-1:0] kl_q;

	assign minlen = eff_min_len(min_len);
	assign n = CMP_W'(sum.count);
	assign too_short = n < minlen;
	assign lim = n - minlen;
	assign start_bad = !sum.start_found || (CMP_W'(sum.start_idx) > lim) ||
		(sum.start_idx > sum.end_idx);
	assign klen = CMP_W'(sum.end_idx) - CMP_W'(sum.start_idx) + CMP_W'(1);
	assign trim_short = klen < minlen;

	always_comb begin
		priority if (sum.overflow) begin
			st = ST_TOO_LONG;
		end else if (too_short) begin
			st = ST_DISCARD;
		end else if (sum.tail_bad) begin
			st = ST_INVALID;
		end else if (!sum.end_found || start_bad || trim_short) begin
			st = ST_DISCARD;
		end else begin
			st = ST_KEEP;
		end
	end

	assign res_free = !v_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (sum.valid) begin
			v_q <= 1'b1;
		end else if (res.ready) begin
			v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sum.valid) begin
			st_q <= st;
			if (st == ST_KEEP) begin
				sp_q <= sum.start_idx;
				ep_q <= sum.end_idx;
				kl_q <= klen[CNT_W-1:0];
			end else begin
				sp_q <= '0;
				ep_q <= '0;
				kl_q <= '0;
			end
		end
	end

	assign res.valid = v_q;
	assign res.status = st_q;
	assign res.start_pos = sp_q;
	assign res.end_pos = ep_q;
	assign res.kept_length = kl_q;

`ifndef ASSERT_OFF
	a_keep_len: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && st_q == ST_KEEP |->
			kl_q == CNT_W'(ep_q) - CNT_W'(sp_q) + CNT_W'(1))
		else $error("kept length does not match positions");
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_q && st_q != ST_KEEP |-> sp_q == '0 && ep_q == '0 && kl_q == '0)
		else $error("non-kept result carries positions");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		sum.valid |-> res_free)
		else $error("result register overwritten while held");
`endif

endmodule

// ----- test/trim_checker.sv -----
`timescale 1ns / 100ps
module trim_checker
	import rqet_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [LEN_W-1:0] cfg_data,
	rqet_qual_if             qual,
	rqet_res_if              res,
	output int               failures,
	output int               pending
);

	typedef struct {
		status_t          status;
		logic [IDX_W-1:0] start_pos;
		logic [IDX_W-1:0] end_pos;
		logic [CNT_W-1:0] kept_length;
	} verdict_t;

	verdict_t verdicts_due[$];

	logic [QW-1:0]    start_q;
	logic [QW-1:0]    end_q;
	logic [QW-1:0]    q_offset;
	logic [LEN_W-1:0] min_len;

	int base_idx;
	int start_at;
	int end_at;
	bit start_seen;
	bit end_seen;
	bit tail_bad;
	bit too_long;

	initial failures = 0;
	initial pending = 0;

	function automatic void clear_read();
		base_idx = 0;
		start_seen = 1'b0;
		start_at = 0;
		end_seen = 1'b0;
		end_at = 0;
		tail_bad = 1'b0;
		too_long = 1'b0;
	endfunction

	// Advances the per-read state by one quality byte; returns 1 with the
	// verdict on the last byte of a read.
	function automatic bit trim_step(input logic [BYTE_W-1:0] qb, input logic lst,
			output verdict_t v);
		int q;
		int minlen;
		bit bad;
		q = int'(qb) - int'(q_offset);
		minlen = (min_len == '0) ? 1 : int'(min_len);
		v.status = ST_DISCARD;
		v.start_pos = '0;
		v.end_pos = '0;
		v.kept_length = '0;
		if (!too_long) begin
			if (base_idx >= MAX_READ_LEN) begin
				too_long = 1'b1;
			end else begin
				bad = (q < 0) || (q > QUAL_MAX);
				if (!start_seen && q >= int'(start_q)) begin
					start_seen = 1'b1;
					start_at = base_idx;
				end
				if (base_idx + 1 >= minlen) begin
					// a new end base resets the tail: only bases from it on count
					if (q >= int'(end_q)) begin
						end_seen = 1'b1;
						end_at = base_idx;
						tail_bad = bad;
					end else if (bad) begin
						tail_bad = 1'b1;
					end
				end
				base_idx++;
			end
		end
		if (!lst)
			return 1'b0;
		if (too_long)
			v.status = ST_TOO_LONG;
		else if (base_idx < minlen)
			v.status = ST_DISCARD;
		else if (tail_bad)
			v.status = ST_INVALID;
		else if (!end_seen)
			v.status = ST_DISCARD;
		else if (!start_seen || start_at > base_idx - minlen || start_at > end_at)
			v.status = ST_DISCARD;
		else if (end_at - start_at + 1 < minlen)
			v.status = ST_DISCARD;
		else begin
			v.status = ST_KEEP;
			v.start_pos = IDX_W'(start_at);
			v.end_pos = IDX_W'(end_at);
			v.kept_length = CNT_W'(end_at - start_at + 1);
		end
		clear_read();
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			start_q = QW'(0);
			end_q = QW'(3);
			min_len = LEN_W'(60);
			q_offset = QW'(33);
			clear_read();
			verdicts_due.delete();
		end else begin
			if (res.valid && res.ready) begin
				got.status = status_t'(res.status);
				got.start_pos = res.start_pos;
				got.end_pos = res.end_pos;
				got.kept_length = res.kept_length;
				if (verdicts_due.size() == 0) begin
					$error("result item with no read pending: status %0d", res.status);
					failures++;
				end else begin
					want = verdicts_due.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						failures++;
					end
					if (got.start_pos !== want.start_pos) begin
						$error("start_pos: expected %0d, got %0d", want.start_pos,
							got.start_pos);
						failures++;
					end
					if (got.end_pos !== want.end_pos) begin
						$error("end_pos: expected %0d, got %0d", want.end_pos, got.end_pos);
						failures++;
					end
					if (got.kept_length !== want.kept_length) begin
						$error("kept_length: expected %0d, got %0d", want.kept_length,
							got.kept_length);
						failures++;
					end
				end
			end
			if (qual.valid && qual.ready) begin
				if (trim_step(qual.quality_byte, qual.last_base, want))
					verdicts_due.push_back(want);
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_START_Q: start_q = cfg_data[QW-1:0];
					CFG_MIN_END_Q:   end_q = cfg_data[QW-1:0];
					CFG_MIN_LEN:     min_len = cfg_data;
					CFG_Q_OFFSET:    q_offset = cfg_data[QW-1:0];
					default: ;
				endcase
			end
		end
		pending = verdicts_due.size();
	end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
	import rqet_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 300;
	localparam logic [BYTE_W-1:0] Q0 = 8'd33;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	cfg_idx_t         cfg_index;
	logic [LEN_W-1:0] cfg_data;

	int failures;
	int pending;
	int src_idle;
	int snk_idle;
	int quiet_cycles = 0;
	int cur_msq;
	int cur_meq;
	int cur_mrl;
	int cur_off;

	rqet_qual_if qual ();
	rqet_res_if  res ();

	read_quality_end_trimmer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.qual      (qual),
		.res       (res)
	);

	trim_checker trim_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.qual      (qual),
		.res       (res),
		.failures  (failures),
		.pending   (pending)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		res.ready <= ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		if ((qual.valid && qual.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic push_base(input logic [BYTE_W-1:0] qb, input logic lst);
		while ($urandom_range(99) < src_idle) begin
			qual.valid <= 1'b0;
			@(negedge clk);
		end
		qual.valid <= 1'b1;
		qual.quality_byte <= qb;
		qual.last_base <= lst;
		@(posedge clk);
		while (!qual.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_one(input cfg_idx_t idx, input logic [LEN_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(negedge clk);
	endtask

	// Only called between reads; waits for the last verdict to drain first.
	task automatic set_trim(input int msq, input int meq, input int mrl, input int off);
		qual.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		// junk in the unused upper data bits of the 7-bit registers
		write_one(CFG_MIN_START_Q, {4'($urandom_range(15)), 7'(msq)});
		write_one(CFG_MIN_END_Q, {4'($urandom_range(15)), 7'(meq)});
		write_one(CFG_MIN_LEN, 11'(mrl));
		write_one(CFG_Q_OFFSET, {4'($urandom_range(15)), 7'(off)});
		cfg_we <= 1'b0;
		cur_msq = msq;
		cur_meq = meq;
		cur_mrl = mrl;
		cur_off = off;
	endtask

	// Clean bytes stay in the legal quality range; noisy ones may not.
	function automatic logic [BYTE_W-1:0] pick_byte(input bit clean);
		int r;
		int thr;
		int v;
		r = $urandom_range(99);
		if (!clean && r < 8)
			v = $urandom_range(255);
		else if (!clean && r < 12)
			v = cur_off + QUAL_MAX + 1 + $urandom_range(30);
		else if (!clean && r < 16)
			v = cur_off - 1 - $urandom_range(20);
		else if (r < 50) begin
			thr = $urandom_range(1) ? cur_msq : cur_meq;
			v = cur_off + thr + $urandom_range(2) - 1;
		end else
			v = cur_off + $urandom_range(40);
		if (clean && (v < cur_off || v - cur_off > QUAL_MAX))
			v = cur_off + $urandom_range(40);
		return v[7:0];
	endfunction

	task automatic send_read(input int len, input bit clean);
		for (int i = 0; i < len; i++)
			push_base(pick_byte(clean), i == len - 1);
	endtask

	initial begin : main
		int seg;
		int n_random;
		int len;
		int m;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MIN_START_Q;
		cfg_data = '0;
		qual.valid = 1'b0;
		qual.quality_byte = '0;
		qual.last_base = 1'b0;
		res.ready = 1'b0;
		src_idle = 16;
		snk_idle = 61;
		cur_msq = 0;
		cur_meq = 3;
		cur_mrl = 60;
		cur_off = 33;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: a read below the 60-base minimum
		push_base(Q0 + 8'd30, 1'b0);
		push_base(Q0 + 8'd30, 1'b0);
		push_base(Q0 + 8'd30, 1'b1);

		set_trim(10, 10, 3, 33);
		// kept with both ends trimmed
		push_base(Q0 + 8'd5, 1'b0);
		push_base(Q0 + 8'd20, 1'b0);
		push_base(Q0 + 8'd20, 1'b0);
		push_base(Q0 + 8'd20, 1'b0);
		push_base(Q0 + 8'd5, 1'b1);
		// negative quality in the tail (byte 0)
		push_base(Q0 + 8'd20, 1'b0);
		push_base(Q0 + 8'd20, 1'b0);
		push_base(Q0 + 8'd20, 1'b0);
		push_base(8'd0, 1'b1);
		// quality above 93 as the end base (byte 255)
		push_base(Q0 + 8'd20, 1'b0);
		push_base(Q0 + 8'd20, 1'b0);
		push_base(8'd255, 1'b1);
		// short read
		push_base(Q0 + 8'd20, 1'b1);
		// first good base too late
		push_base(Q0 + 8'd5, 1'b0);
		push_base(Q0 + 8'd5, 1'b0);
		push_base(Q0 + 8'd20, 1'b0);
		push_base(Q0 + 8'd20, 1'b1);
		// no end base past the minimum
		push_base(Q0 + 8'd20, 1'b0);
		push_base(Q0 + 8'd20, 1'b0);
		push_base(Q0 + 8'd5, 1'b1);

		seg = 0;
		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			if (n_random < RANDOM_ITEMS / 3) begin
				src_idle = 16;
				snk_idle = 61;
			end else if (n_random < 2 * RANDOM_ITEMS / 3) begin
				src_idle = 61;
				snk_idle = 16;
			end else begin
				src_idle = 0;
				snk_idle = 0;
			end
			case (seg)
				0: set_trim(0, 0, 0, 33);
				1: set_trim(127, 127, 1, 64);
				2: set_trim(0, 127, 1, 33);
				3: set_trim(127, 0, 5, 64);
				4: set_trim(30, 30, 1, 0);
				5: set_trim(2, 40, 10, 127);
				default: set_trim($urandom_range(45), $urandom_range(45),
					($urandom_range(99) < 15) ? $urandom_range(25, 64) : $urandom_range(24),
					($urandom_range(99) < 90) ? ($urandom_range(1) ? 33 : 64)
						: $urandom_range(127));
			endcase
			repeat ($urandom_range(6, 14)) begin
				m = (cur_mrl == 0) ? 1 : cur_mrl;
				len = ($urandom_range(99) < 15) ? $urandom_range(1, m)
					: m + $urandom_range(10);
				send_read(len, $urandom_range(99) < 60);
				n_random += len;
			end
			seg++;
		end

		// a noisy read over the length limit, then a short read under a minimum above the limit
		set_trim(20, 10, 1000, 64);
		send_read(1030, 1'b0);
		set_trim(0, 3, 2047, 33);
		send_read(8, 1'b1);

		qual.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
